// ===== hw/rtl/ippc_pkg.sv =====
// Shared types and constants of the per-protocol packet counter.
// No dependencies; imported by the out interface, the top level and the checker.
`timescale 1ns / 1ps

package ippc_pkg;

  localparam int OUT_COUNT_W = 64;

  localparam logic OP_FRAME_BYTE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;

  localparam logic [5:0] POS_ETYPE_HI = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO = 6'd13;
  localparam logic [5:0] POS_IPV6_NH  = 6'd20;
  localparam logic [5:0] POS_IPV4_PR  = 6'd23;
  localparam logic [5:0] POS_MAX      = 6'd63;

  localparam logic [6:0] LEN_MIN_ETH  = 7'd14;
  localparam logic [6:0] LEN_MIN_IP   = 7'd34;
  localparam logic [6:0] LEN_MIN_IPV6 = 7'd54;

  typedef struct packed {
    logic       verdict;
    logic       counted;
    logic [7:0] protocol;
    logic       show_count;
  } ippc_res_t;

endpackage

// ===== hw/rtl/ippc_if.sv =====
// Valid/ready channels of the packet counter: request channel and result channel.
// Depends on ippc_pkg.
`timescale 1ns / 1ps

interface ippc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic [7:0] read_index;

  modport source (output valid, operation, frame_byte, last_byte, read_index, input ready);
  modport sink   (input valid, operation, frame_byte, last_byte, read_index, output ready);
endinterface

interface ippc_out_if import ippc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   verdict;
  logic                   counted;
  logic [7:0]             protocol;
  logic [OUT_COUNT_W-1:0] count;

  modport source (output valid, verdict, counted, protocol, count, input ready);
  modport sink   (input valid, verdict, counted, protocol, count, output ready);
endinterface

// ===== hw/rtl/ip_protocol_packet_counter_top.sv =====
// Results pass the update stage (s1) and the result register to the out channel.
// Throughput: one request per cycle while out_chan is not stalled; the counter store has one
// read and one write port, with a bypass of the last write into the read-modify-write stage.
// Reset (synchronous, active low) clears the frame parser, the pipeline and the
// per-entry valid bits; an entry never written reads as zero, so no clearing pass runs.
// Depends on ippc_pkg and ippc_if.
`timescale 1ns / 1ps

module ip_protocol_packet_counter_top import ippc_pkg::*; #(
  parameter int COUNTER_ENTRIES = 256,
  parameter int COUNT_WIDTH     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ippc_in_if.sink     in_chan,
  ippc_out_if.source  out_chan
);

  localparam int         AW          = (COUNTER_ENTRIES > 1) ? $clog2(COUNTER_ENTRIES) : 1;
  localparam logic [8:0] ENTRIES_LIM = 9'(COUNTER_ENTRIES);

  // frame parser state
  logic [5:0]  pos_r;
  logic [15:0] etype_r;
  logic [7:0]  ipv4_pr_r;
  logic [7:0]  ipv6_nh_r;

  // counter store
  logic [COUNT_WIDTH-1:0] mem [COUNTER_ENTRIES];
  logic                   ent_vld_r [COUNTER_ENTRIES];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   rd_vld_r;

  // last write bypass
  logic                   fwd_vld_r;
  logic [AW-1:0]          fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  // update stage
  logic          s1_vld_r;
  ippc_res_t     s1_r;
  ippc_res_t     s1_nxt;
  logic [AW-1:0] s1_addr_r;

  // result register
  logic                   out_vld_r;
  logic                   out_verdict_r;
  logic                   out_counted_r;
  logic [7:0]             out_protocol_r;
  logic [OUT_COUNT_W-1:0] out_count_r;

  logic                   in_fire;
  logic                   is_read;
  logic                   byte_fire;
  logic                   res_fire;
  logic [6:0]             len;
  logic                   len_lt_eth;
  logic                   len_lt_ip;
  logic [7:0]             proto_sel;
  logic [7:0]             frame_proto;
  logic                   cnt_en;
  logic                   read_ok;
  logic [7:0]             iss_idx;
  logic [AW-1:0]          iss_addr;
  logic                   s1_adv;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic [COUNT_WIDTH-1:0] res_cnt;
  logic                   wr_en;

  assign s1_adv        = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !s1_vld_r || s1_adv;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign is_read       = (in_chan.operation == OP_READ);
  assign byte_fire     = in_fire && !is_read;
  assign res_fire      = in_fire && (is_read || in_chan.last_byte);

  assign len        = {1'b0, pos_r} + 7'd1;
  assign len_lt_eth = len < LEN_MIN_ETH;
  assign len_lt_ip  = len < LEN_MIN_IP;

  always_comb begin
    if (etype_r == ETH_TYPE_IPV4) begin
      proto_sel = ipv4_pr_r;
    end else if (etype_r == ETH_TYPE_IPV6 && !(len < LEN_MIN_IPV6)) begin
      proto_sel = ipv6_nh_r;
    end else begin
      proto_sel = 8'd0;
    end
  end

  assign frame_proto = len_lt_ip ? 8'd0 : proto_sel;
  assign cnt_en      = (frame_proto != 8'd0) && ({1'b0, frame_proto} < ENTRIES_LIM);
  assign read_ok     = {1'b0, in_chan.read_index} < ENTRIES_LIM;
  assign iss_idx     = is_read ? in_chan.read_index : frame_proto;
  assign iss_addr    = iss_idx[AW-1:0];

  always_comb begin
    s1_nxt = '0;
    if (is_read) begin
      s1_nxt.show_count = read_ok;
    end else begin
      s1_nxt.verdict  = !len_lt_eth && len_lt_ip;
      s1_nxt.counted  = cnt_en;
      s1_nxt.protocol = frame_proto;
    end
  end

  // frame parser
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      etype_r   <= '0;
      ipv4_pr_r <= '0;
      ipv6_nh_r <= '0;
    end else if (byte_fire) begin
      if (in_chan.last_byte) begin
        pos_r     <= '0;
        etype_r   <= '0;
        ipv4_pr_r <= '0;
        ipv6_nh_r <= '0;
      end else begin
        if (pos_r < POS_MAX) begin
          pos_r <= pos_r + 6'd1;
        end
        case (pos_r)
          POS_ETYPE_HI: etype_r[15:8] <= in_chan.frame_byte;
          POS_ETYPE_LO: etype_r[7:0]  <= in_chan.frame_byte;
          POS_IPV6_NH:  ipv6_nh_r     <= in_chan.frame_byte;
          POS_IPV4_PR:  ipv4_pr_r     <= in_chan.frame_byte;
          default: ;
        endcase
      end
    end
  end

  // update stage: read-modify-write of one counter, or a plain read for a read request
  assign cur_cnt = (fwd_vld_r && fwd_addr_r == s1_addr_r) ? fwd_data_r :
                   (rd_vld_r ? rd_data_r : '0);
  assign inc_cnt = cur_cnt + COUNT_WIDTH'(1);
  assign res_cnt = s1_r.counted ? inc_cnt : (s1_r.show_count ? cur_cnt : '0);
  assign wr_en   = s1_vld_r && s1_adv && s1_r.counted;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= inc_cnt;
    end
    if (res_fire) begin
      rd_data_r <= mem[iss_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COUNTER_ENTRIES; i++) begin
        ent_vld_r[i] <= 1'b0;
      end
      fwd_vld_r <= 1'b0;
    end else if (wr_en) begin
      ent_vld_r[s1_addr_r] <= 1'b1;
      fwd_vld_r            <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= inc_cnt;
    end
    if (res_fire) begin
      rd_vld_r  <= ent_vld_r[iss_addr];
      s1_r      <= s1_nxt;
      s1_addr_r <= iss_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (res_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_vld_r && s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_adv) begin
      out_verdict_r  <= s1_r.verdict;
      out_counted_r  <= s1_r.counted;
      out_protocol_r <= s1_r.protocol;
      out_count_r    <= OUT_COUNT_W'(res_cnt);
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.verdict  = out_verdict_r;
  assign out_chan.counted  = out_counted_r;
  assign out_chan.protocol = out_protocol_r;
  assign out_chan.count    = out_count_r;

endmodule

// ===== hw/rtl/ippc_checker.sv =====
// Port-level checks of the packet counter results, bound to the top level.
// Depends on ippc_pkg and ip_protocol_packet_counter_top.
`timescale 1ns / 1ps

module ippc_checker import ippc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   verdict,
  input logic                   counted,
  input logic [7:0]             protocol,
  input logic [OUT_COUNT_W-1:0] count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(count) && $stable(protocol))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict |-> !counted && protocol == 8'd0 && count == '0)
    else $error("aborted frame carries a protocol or count");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && counted |-> protocol != 8'd0 && count != '0)
    else $error("counted frame without protocol or with zero count");

endmodule

bind ip_protocol_packet_counter_top ippc_checker u_ippc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .verdict   (out_chan.verdict),
  .counted   (out_chan.counted),
  .protocol  (out_chan.protocol),
  .count     (out_chan.count)
);
